// ===== rtl/ppnf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppnf_pkg
// Shared types and constants of the particle pool with next-fit slot search.
// ----------------------------------------------------------------------------
`default_nettype none

package ppnf_pkg;

    // Pool geometry.
    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    // Field widths fixed by the item formats.
    localparam int SLOT_W    = 6;
    localparam int LCNT_W    = 7;
    localparam int POS_W     = 16;
    localparam int SIZE_W    = 10;
    localparam int RGBA_W    = 32;
    localparam int LIFE_W    = 16;
    localparam int DT_W      = 16;
    localparam int RATE_W    = 16;

    // Life arithmetic: the Q8.8 rate times the Q0.16 time step gives Q8.24;
    // dropping nine bits leaves a Q8.15 loss in the units of the Q1.15 life.
    localparam int                PROD_W      = RATE_W + DT_W;
    localparam int                LOSS_SHIFT  = 9;
    localparam int                LOSS_W      = PROD_W - LOSS_SHIFT;
    localparam logic [LIFE_W-1:0] FULL_LIFE   = 16'h8000;
    localparam logic [RATE_W-1:0] DECAY_RESET = 16'd256;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_DRAW = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd                     cmd;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [SIZE_W-1:0]        size_px;
        logic [RGBA_W-1:0]        rgba;
        logic [DT_W-1:0]          delta_time;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]        slot;
        logic signed [POS_W-1:0]  out_x;
        logic signed [POS_W-1:0]  out_y;
        logic [SIZE_W-1:0]        out_size;
        logic [RGBA_W-1:0]        out_rgba;
        logic [LIFE_W-1:0]        out_life;
        logic [LCNT_W-1:0]        live_count;
        logic                     last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_ADD,
        S_MUL,
        S_TICK,
        S_TICK_OUT,
        S_EMPTY,
        S_DRAW
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic             item_ld;
        logic             loss_ld;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             life_wr;
        logic             add_wr;
        logic [IDX_W-1:0] wr_addr;
        logic             out_ld;
        logic             out_draw;
        logic [IDX_W-1:0] out_slot;
        logic [CNT_W-1:0] out_cnt;
        logic             out_last;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic life_nz;
        logic new_nz;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/ppnf_datapath.sv =====
// ----------------------------------------------------------------------------
// ppnf_datapath
// Slot memories, life valid bits, decay multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppnf_datapath import ppnf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_in_item          i_in_item,
    input  wire logic              i_cfg_we,
    input  wire logic [RATE_W-1:0] i_cfg_data,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output t_out_item              o_out_item
);

    logic [RATE_W-1:0]        r_decay;
    t_in_item                 r_item;
    logic [LOSS_W-1:0]        r_loss;

    logic [LIFE_W-1:0]        life_mem  [POOL_SIZE];
    logic signed [POS_W-1:0]  xpos_mem  [POOL_SIZE];
    logic signed [POS_W-1:0]  ypos_mem  [POOL_SIZE];
    logic [SIZE_W-1:0]        size_mem  [POOL_SIZE];
    logic [RGBA_W-1:0]        color_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0]     r_vld;

    logic [LIFE_W-1:0]        r_life_q;
    logic                     r_vld_q;
    logic signed [POS_W-1:0]  r_x_q;
    logic signed [POS_W-1:0]  r_y_q;
    logic [SIZE_W-1:0]        r_size_q;
    logic [RGBA_W-1:0]        r_rgba_q;

    logic                     r_out_valid;
    logic                     n_out_valid;
    t_out_item                r_out;
    t_out_item                n_out;

    logic [PROD_W-1:0]        w_prod;
    logic [LIFE_W-1:0]        w_life;
    logic                     w_life_gt;
    logic [LIFE_W-1:0]        w_new_life;
    logic                     w_life_we;
    logic [LIFE_W-1:0]        w_life_wdata;

    assign w_prod = PROD_W'(r_decay) * PROD_W'(r_item.delta_time);

    // A slot never written since reset reads as free.
    assign w_life     = r_vld_q ? r_life_q : '0;
    assign w_life_gt  = LOSS_W'(w_life) > r_loss;
    assign w_new_life = w_life_gt ? (w_life - r_loss[LIFE_W-1:0]) : '0;

    assign w_life_we    = i_cmd.life_wr || i_cmd.add_wr;
    assign w_life_wdata = i_cmd.add_wr ? FULL_LIFE : w_new_life;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= DECAY_RESET;
        end else if (i_cfg_we) begin
            r_decay <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_ld) begin
            r_item <= i_in_item;
        end
        if (i_cmd.loss_ld) begin
            r_loss <= w_prod[PROD_W-1:LOSS_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_life_we) begin
            r_vld[i_cmd.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_life_we) begin
            life_mem[i_cmd.wr_addr] <= w_life_wdata;
        end
        if (i_cmd.add_wr) begin
            xpos_mem[i_cmd.wr_addr]  <= r_item.pos_x;
            ypos_mem[i_cmd.wr_addr]  <= r_item.pos_y;
            size_mem[i_cmd.wr_addr]  <= r_item.size_px;
            color_mem[i_cmd.wr_addr] <= r_item.rgba;
        end
        if (i_cmd.rd_en) begin
            r_life_q <= life_mem[i_cmd.rd_addr];
            r_vld_q  <= r_vld[i_cmd.rd_addr];
            r_x_q    <= xpos_mem[i_cmd.rd_addr];
            r_y_q    <= ypos_mem[i_cmd.rd_addr];
            r_size_q <= size_mem[i_cmd.rd_addr];
            r_rgba_q <= color_mem[i_cmd.rd_addr];
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.slot       = SLOT_W'(i_cmd.out_slot);
        n_out.live_count = LCNT_W'(i_cmd.out_cnt);
        n_out.last       = i_cmd.out_last;
        if (i_cmd.out_draw) begin
            n_out.out_x    = r_x_q;
            n_out.out_y    = r_y_q;
            n_out.out_size = r_size_q;
            n_out.out_rgba = r_rgba_q;
            n_out.out_life = w_life;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out <= n_out;
        end
    end

    assign o_sts.life_nz  = w_life != '0;
    assign o_sts.new_nz   = w_new_life != '0;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ===== rtl/ppnf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppnf_ctrl
// Sequencer for add, tick and draw: walks the slots one per cycle, but a draw
// holds on a busy result register; keeps the live count and next-fit start slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ppnf_ctrl import ppnf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_cmd    i_in_cmd,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_SIZE);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_rd_done;
    logic             n_rd_done;
    logic             r_chk;
    logic             n_chk;
    logic [IDX_W-1:0] r_chk_idx;
    logic [IDX_W-1:0] n_chk_idx;
    logic [IDX_W-1:0] r_slot;
    logic [IDX_W-1:0] n_slot;
    logic [IDX_W-1:0] r_search;
    logic [IDX_W-1:0] n_search;
    logic [CNT_W-1:0] r_live;
    logic [CNT_W-1:0] n_live;
    logic [CNT_W-1:0] r_acc;
    logic [CNT_W-1:0] n_acc;
    logic [CNT_W-1:0] r_emit;
    logic [CNT_W-1:0] n_emit;

    logic w_accept;
    logic w_full;
    logic w_found;
    logic w_tick_end;
    logic w_draw_fire;
    logic w_draw_last;
    logic w_stall;
    logic w_advance;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_full      = r_live == FULL_CNT;
    assign w_found     = (r_state == S_FIND) && r_chk && !i_sts.life_nz;
    assign w_tick_end  = (r_state == S_TICK) && r_chk && (r_chk_idx == LAST_IDX);
    assign w_draw_fire = (r_state == S_DRAW) && r_chk && i_sts.life_nz && i_sts.out_free;
    assign w_draw_last = (r_emit + CNT_W'(1)) == r_live;
    // A live slot waiting on a busy result register holds the read registers.
    assign w_stall     = (r_state == S_DRAW) && r_chk && i_sts.life_nz && !i_sts.out_free;
    assign w_advance   = (r_state == S_FIND) || (r_state == S_TICK) ||
                         ((r_state == S_DRAW) && !w_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_cmd)
                        CMD_ADD:  n_state = w_full ? S_ADD : S_FIND;
                        CMD_TICK: n_state = S_MUL;
                        CMD_DRAW: n_state = (r_live == '0) ? S_EMPTY : S_DRAW;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_FIND: begin
                if (w_found) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_TICK;
            end
            S_TICK: begin
                if (w_tick_end) begin
                    n_state = S_TICK_OUT;
                end
            end
            S_TICK_OUT, S_EMPTY: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DRAW: begin
                if (w_draw_fire && w_draw_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = r_state == S_IDLE;
        o_cmd         = '0;
        o_cmd.item_ld = w_accept;
        o_cmd.rd_en   = w_advance;
        o_cmd.rd_addr = r_idx;
        unique case (r_state)
            S_MUL: begin
                o_cmd.loss_ld = 1'b1;
            end
            S_TICK: begin
                o_cmd.life_wr = r_chk && i_sts.life_nz;
                o_cmd.wr_addr = r_chk_idx;
            end
            S_ADD: begin
                o_cmd.add_wr   = i_sts.out_free;
                o_cmd.wr_addr  = r_slot;
                o_cmd.out_ld   = i_sts.out_free;
                o_cmd.out_slot = r_slot;
                o_cmd.out_last = 1'b1;
            end
            S_TICK_OUT: begin
                o_cmd.out_ld   = i_sts.out_free;
                o_cmd.out_cnt  = r_live;
                o_cmd.out_last = 1'b1;
            end
            S_EMPTY: begin
                o_cmd.out_ld   = i_sts.out_free;
                o_cmd.out_last = 1'b1;
            end
            S_DRAW: begin
                o_cmd.out_ld   = w_draw_fire;
                o_cmd.out_draw = 1'b1;
                o_cmd.out_slot = r_chk_idx;
                o_cmd.out_cnt  = r_live;
                o_cmd.out_last = w_draw_last;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_idx     = r_idx;
        n_rd_done = r_rd_done;
        n_chk     = r_chk;
        n_chk_idx = r_chk_idx;
        n_slot    = r_slot;
        n_search  = r_search;
        n_live    = r_live;
        n_acc     = r_acc;
        n_emit    = r_emit;

        if (w_accept) begin
            // A full pool overwrites slot 0 without searching.
            n_idx     = (i_in_cmd == CMD_ADD) ? r_search : '0;
            n_rd_done = 1'b0;
            n_chk     = 1'b0;
            n_slot    = '0;
            n_acc     = '0;
            n_emit    = '0;
        end

        if (w_advance) begin
            n_chk     = !r_rd_done;
            n_chk_idx = r_idx;
            if (!r_rd_done) begin
                if (r_idx == LAST_IDX) begin
                    n_idx     = '0;
                    n_rd_done = r_state != S_FIND;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
        end

        if (w_found) begin
            n_slot   = r_chk_idx;
            n_search = r_chk_idx;
        end

        if ((r_state == S_ADD) && i_sts.out_free && !w_full) begin
            n_live = r_live + CNT_W'(1);
        end

        if ((r_state == S_TICK) && r_chk) begin
            n_acc = r_acc + CNT_W'(i_sts.new_nz);
            if (w_tick_end) begin
                n_live = r_acc + CNT_W'(i_sts.new_nz);
            end
        end

        if (w_draw_fire) begin
            n_emit = r_emit + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_rd_done <= 1'b0;
            r_chk     <= 1'b0;
            r_chk_idx <= '0;
            r_slot    <= '0;
            r_search  <= '0;
            r_live    <= '0;
            r_acc     <= '0;
            r_emit    <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_rd_done <= n_rd_done;
            r_chk     <= n_chk;
            r_chk_idx <= n_chk_idx;
            r_slot    <= n_slot;
            r_search  <= n_search;
            r_live    <= n_live;
            r_acc     <= n_acc;
            r_emit    <= n_emit;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/particle_pool_next_fit.sv =====
// ----------------------------------------------------------------------------
// particle_pool_next_fit
// Fixed pool of particle slots with next-fit allocation, aging and listing.
// ----------------------------------------------------------------------------
// Each input transfer is one command. An add scans slots from the remembered
// start, one per cycle, until a free one is found (a full pool skips the scan
// and reuses slot 0). A tick first forms the rate times time product and then
// sweeps every slot once. A draw sweeps the slots in order and sends one result
// per live particle, or a single empty result when the pool is empty; its sweep
// stalls at a live slot while the result register is still full. The slot
// memories have a single read port, visited one slot per cycle. The block takes
// a new command only between commands, but a finished result may still be
// waiting in the output register when the next command is accepted.
// The decay rate register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_next_fit import ppnf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [RATE_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ppnf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_item.cmd),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ppnf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/ppnf_checker.sv =====
// ----------------------------------------------------------------------------
// ppnf_checker
// Port-level checks of the particle pool, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppnf_checker import ppnf_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire t_out_item         o_out_item
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // More draw results are still to come, so no new command may be taken.
    a_busy_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> !o_in_ready)
        else $error("command accepted in the middle of a draw");

    // Only draws of live particles produce results that are not the last.
    a_draw_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |->
            (o_out_item.out_life != '0) && (o_out_item.live_count > LCNT_W'(1)))
        else $error("non-final result without a live particle");

    // Consecutive draw results come in rising slot order.
    a_draw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_ready && !o_out_item.last) && o_out_valid
            |-> o_out_item.slot > $past(o_out_item.slot))
        else $error("draw results out of slot order");

endmodule

bind particle_pool_next_fit ppnf_checker u_ppnf_checker (.*);

`default_nettype wire

// ===== dv/particle_pool_next_fit_tb.sv =====
// ----------------------------------------------------------------------------
// particle_pool_next_fit_tb
// Self-checking bench for the particle pool with next-fit slot allocation.
// A local copy of the pool state predicts the result of every accepted add,
// tick and draw command. Each result transfer is compared field by field
// with the oldest prediction. Directed tests cover the empty pool, field
// extremes, decay down to zero and the full pool. Random traffic then runs
// under four handshake idling modes and several decay rates.
// ----------------------------------------------------------------------------
module particle_pool_next_fit_tb import ppnf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         MAX_REPORTS    = 10;
    localparam int         MAX_GAP        = 30;
    localparam int         SETTLE_CYCLES  = 2 * POOL_SIZE + 8;
    localparam int         WATCHDOG_LIMIT = 2000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_item          in_item = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [RATE_W-1:0] cfg_data = '0;

    t_idle_mode idle_mode = IDLE_NONE;

    // Predicted pool contents.
    logic [LIFE_W-1:0]       life_tbl [POOL_SIZE];
    logic signed [POS_W-1:0] x_tbl    [POOL_SIZE];
    logic signed [POS_W-1:0] y_tbl    [POOL_SIZE];
    logic [SIZE_W-1:0]       size_tbl [POOL_SIZE];
    logic [RGBA_W-1:0]       color_tbl[POOL_SIZE];
    int unsigned             next_start;
    logic [RATE_W-1:0]       decay_rate;

    t_out_item pending_results[$];

    int n_adds, n_full_adds, n_ticks, n_draws, n_empty_draws, n_ignored;
    int n_results, n_rate_writes, mismatch_count, stalled_cycles;

    particle_pool_next_fit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned live_slots();
        int unsigned c;
        c = 0;
        for (int s = 0; s < POOL_SIZE; s++) begin
            if (life_tbl[s] != '0) c++;
        end
        return c;
    endfunction

    // Applies one accepted command to the predicted pool and queues the
    // results it must produce.
    function automatic void predict_pool_results(input t_in_item it);
        t_out_item   r;
        int unsigned live, k, s;
        bit          found;
        logic [31:0] loss;
        r = '0;
        case (it.cmd)
            CMD_ADD: begin
                n_adds++;
                found = 1'b0;
                s = 0;
                // Next-fit: from the remembered slot to the end, then wrap.
                for (int i = 0; i < POOL_SIZE && !found; i++) begin
                    if (life_tbl[(next_start + i) % POOL_SIZE] == '0) begin
                        s = (next_start + i) % POOL_SIZE;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    next_start = s;
                end else begin
                    n_full_adds++;
                end
                life_tbl[s]  = FULL_LIFE;
                x_tbl[s]     = it.pos_x;
                y_tbl[s]     = it.pos_y;
                size_tbl[s]  = it.size_px;
                color_tbl[s] = it.rgba;
                r.slot = SLOT_W'(s);
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            CMD_TICK: begin
                n_ticks++;
                loss = (32'(decay_rate) * 32'(it.delta_time)) >> LOSS_SHIFT;
                for (int i = 0; i < POOL_SIZE; i++) begin
                    if (life_tbl[i] != '0) begin
                        life_tbl[i] = (32'(life_tbl[i]) > loss) ?
                                      life_tbl[i] - loss[LIFE_W-1:0] : '0;
                    end
                end
                r.live_count = LCNT_W'(live_slots());
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            CMD_DRAW: begin
                n_draws++;
                live = live_slots();
                if (live == 0) begin
                    n_empty_draws++;
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end else begin
                    k = 0;
                    for (int i = 0; i < POOL_SIZE; i++) begin
                        if (life_tbl[i] != '0) begin
                            r.slot       = SLOT_W'(i);
                            r.out_x      = x_tbl[i];
                            r.out_y      = y_tbl[i];
                            r.out_size   = size_tbl[i];
                            r.out_rgba   = color_tbl[i];
                            r.out_life   = life_tbl[i];
                            r.live_count = LCNT_W'(live);
                            r.last       = (k + 1 == live);
                            pending_results.push_back(r);
                            k++;
                        end
                    end
                end
            end
            default: begin
                n_ignored++;
            end
        endcase
    endfunction

    function automatic t_in_item rand_item(input t_cmd c);
        t_in_item it;
        it.cmd        = c;
        it.pos_x      = POS_W'($urandom);
        it.pos_y      = POS_W'($urandom);
        it.size_px    = SIZE_W'($urandom);
        it.rgba       = $urandom;
        it.delta_time = DT_W'($urandom);
        return it;
    endfunction

    function automatic string fmt_result(input t_out_item r);
        return $sformatf("slot=%0d x=%0d y=%0d size=%0d rgba=%h life=%0d live=%0d last=%0b",
                         r.slot, r.out_x, r.out_y, r.out_size, r.out_rgba, r.out_life,
                         r.live_count, r.last);
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t ns: unexpected result %s", $time, fmt_result(out_item));
                end
            end else begin
                want = pending_results.pop_front();
                if (out_item.slot !== want.slot || out_item.out_x !== want.out_x ||
                    out_item.out_y !== want.out_y || out_item.out_size !== want.out_size ||
                    out_item.out_rgba !== want.out_rgba ||
                    out_item.out_life !== want.out_life ||
                    out_item.live_count !== want.live_count ||
                    out_item.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t ns: mismatch, expected %s", $time, fmt_result(want));
                        $display("%0t ns:           actual   %s", $time,
                                 fmt_result(out_item));
                    end
                end
            end
        end
    end

    // Receiver stalls.
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: out_ready <= ($urandom_range(0, 99) >= 48);
            IDLE_BOTH:     out_ready <= ($urandom_range(0, 99) >= 6);
            default:       out_ready <= 1'b1;
        endcase
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
                         WATCHDOG_LIMIT, pending_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Valid is kept high after a transfer when the next item follows at once,
    // so the payload and valid change with a single assignment each.
    task automatic send_item(input t_in_item it);
        int pct, gap;
        pct = (idle_mode == IDLE_SENDER) ? 48 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        predict_pool_results(it);
    endtask

    task automatic send_tick(input logic [DT_W-1:0] dt);
        t_in_item it;
        it = rand_item(CMD_TICK);
        it.delta_time = dt;
        send_item(it);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_decay_rate(input logic [RATE_W-1:0] rate);
        wait_for_results();
        // An ignored command leaves no result behind, so give the block time
        // to settle before touching the register.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        do @(posedge i_clk); while (!cfg_ready);
        decay_rate = rate;
        n_rate_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_pool();
        idle_mode = IDLE_NONE;
        send_item(rand_item(CMD_DRAW));
        send_tick('0);
        send_tick('1);
        send_item(rand_item(t_cmd'(CMD_UNUSED)));
        send_item(rand_item(CMD_DRAW));
    endtask

    task automatic test_field_extremes();
        t_in_item it;
        it = rand_item(CMD_ADD);
        it.pos_x = 16'sh8000;
        it.pos_y = 16'sh7fff;
        it.size_px = '1;
        it.rgba = '1;
        send_item(it);
        it = rand_item(CMD_ADD);
        it.pos_x = 16'sh7fff;
        it.pos_y = 16'sh8000;
        it.size_px = '0;
        it.rgba = '0;
        send_item(it);
        it = rand_item(CMD_ADD);
        it.pos_x = '0;
        it.pos_y = -16'sd1;
        it.size_px = 10'd1;
        it.rgba = 32'h8000_0001;
        send_item(it);
        send_item(rand_item(CMD_DRAW));
    endtask

    // At the reset rate of 1.0 per second, a full time step leaves life 1.
    task automatic test_life_decay();
        send_tick('1);
        send_item(rand_item(CMD_DRAW));
        send_tick(16'd1);
        send_tick(16'd2);
        send_item(rand_item(CMD_DRAW));
        send_item(rand_item(CMD_ADD));
        send_item(rand_item(t_cmd'(CMD_UNUSED)));
        send_item(rand_item(CMD_ADD));
        send_item(rand_item(CMD_DRAW));
    endtask

    task automatic test_pool_full();
        idle_mode = IDLE_BOTH;
        set_decay_rate('0);
        while (live_slots() < POOL_SIZE) send_item(rand_item(CMD_ADD));
        send_tick('1);
        // With no free slot, adds reuse slot 0.
        send_item(rand_item(CMD_ADD));
        send_item(rand_item(CMD_ADD));
        send_item(rand_item(CMD_DRAW));
        set_decay_rate('1);
        send_tick(16'd1);
        send_tick('1);
        send_item(rand_item(CMD_ADD));
        send_item(rand_item(CMD_ADD));
        send_item(rand_item(CMD_DRAW));
    endtask

    task automatic test_random_traffic(input t_idle_mode mode, input logic [RATE_W-1:0] rate,
                                       input int n_items);
        int sent, pick;
        t_in_item it;
        set_decay_rate(rate);
        idle_mode = mode;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_item(rand_item(t_cmd'(CMD_UNUSED)));
            end else begin
                if (pick < 60) begin
                    it = rand_item(CMD_ADD);
                end else if (pick < 80) begin
                    it = rand_item(CMD_TICK);
                    pick = $urandom_range(0, 9);
                    if (pick < 6) begin
                        it.delta_time = DT_W'($urandom_range(0, 400));
                    end else if (pick == 9) begin
                        it.delta_time = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    end
                end else begin
                    it = rand_item(CMD_DRAW);
                end
                send_item(it);
                sent++;
                if (sent % 45 == 44) wait_for_results();
            end
        end
    endtask

    initial begin
        for (int s = 0; s < POOL_SIZE; s++) life_tbl[s] = '0;
        next_start = 0;
        decay_rate = DECAY_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pool();
        test_field_extremes();
        test_life_decay();
        test_pool_full();
        test_random_traffic(IDLE_NONE, RATE_W'($urandom_range(1, 1023)), 90);
        test_random_traffic(IDLE_SENDER, '1, 90);
        test_random_traffic(IDLE_RECEIVER, '0, 90);
        test_random_traffic(IDLE_BOTH, DECAY_RESET, 90);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d adds (%0d into a full pool), %0d ticks, %0d draws (%0d empty),",
                 n_adds, n_full_adds, n_ticks, n_draws, n_empty_draws);
        $display("%0d ignored commands; %0d results checked over %0d rate writes, %0d bad.",
                 n_ignored, n_results, n_rate_writes, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
